FILE: hdl/aesd_pkg.sv
`timescale 1ns / 1ps

package aesd_pkg;

  localparam int ROUNDS    = 10;
  localparam int RK_IDX_W  = $clog2(ROUNDS + 1);
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IV_LOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHAIN_MODE = 3'd4;

  localparam logic [7:0] RCON_FIRST = 8'h01;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } core_state_t;

  typedef struct packed {
    logic [127:0] iv;
    logic         chain_mode;
  } chain_cfg_t;

  localparam logic [2047:0] FWD_SBOX = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  localparam logic [2047:0] INV_SBOX = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
  };

  function automatic logic [7:0] fwd_sub(input logic [7:0] b);
    return FWD_SBOX[2047 - 8 * b -: 8];
  endfunction

  function automatic logic [7:0] inv_sub(input logic [7:0] b);
    return INV_SBOX[2047 - 8 * b -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] next_round_key(input logic [127:0] rk,
                                                  input logic [7:0] rc);
    logic [31:0] t;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    t = {fwd_sub(rk[23:16]), fwd_sub(rk[15:8]), fwd_sub(rk[7:0]), fwd_sub(rk[31:24])};
    t = t ^ {rc, 24'h000000};
    w0 = rk[127:96] ^ t;
    w1 = rk[95:64] ^ w0;
    w2 = rk[63:32] ^ w1;
    w3 = rk[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127 - 8 * (r + 4 * c) -: 8] = inv_sub(s[127 - 8 * (r + 4 * ((c - r + 4) % 4)) -: 8]);
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] m11 [4];
    logic [7:0] m13 [4];
    logic [7:0] m14 [4];
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a[k]   = s[127 - 8 * (4 * c + k) -: 8];
        x2[k]  = xtime(a[k]);
        x4[k]  = xtime(x2[k]);
        x8[k]  = xtime(x4[k]);
        m9[k]  = x8[k] ^ a[k];
        m11[k] = x8[k] ^ x2[k] ^ a[k];
        m13[k] = x8[k] ^ x4[k] ^ a[k];
        m14[k] = x8[k] ^ x4[k] ^ x2[k];
      end
      t[127 - 8 * (4 * c) -: 8]     = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
      t[127 - 8 * (4 * c + 1) -: 8] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
      t[127 - 8 * (4 * c + 2) -: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
      t[127 - 8 * (4 * c + 3) -: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
    end
    return t;
  endfunction

endpackage

FILE: hdl/aesd_if.sv
`timescale 1ns / 1ps

interface aesd_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] ct_high;
  logic [63:0] ct_low;
  logic        first_block;
  modport source (output valid, ct_high, ct_low, first_block, input ready);
  modport sink (input valid, ct_high, ct_low, first_block, output ready);
endinterface

interface aesd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] pt_high;
  logic [63:0] pt_low;
  modport source (output valid, pt_high, pt_low, input ready);
  modport sink (input valid, pt_high, pt_low, output ready);
endinterface

interface aesd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [aesd_pkg::CFG_IDX_W-1:0] index;
  logic [63:0]                    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/aesd_keymem.sv
`timescale 1ns / 1ps

module aesd_keymem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [127:0]                  key,
  input  logic [aesd_pkg::RK_IDX_W-1:0] rd_addr,
  output logic [127:0]                  rd_data,
  output logic                          busy
);

  logic [127:0] mem [aesd_pkg::ROUNDS + 1];

  logic                          busy_r;
  logic [aesd_pkg::RK_IDX_W-1:0] idx_r;
  logic [127:0]                  cur_r;
  logic [7:0]                    rc_r;
  logic [127:0]                  rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
      cur_r  <= '0;
      rc_r   <= aesd_pkg::RCON_FIRST;
    end else if (start) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
      cur_r  <= key;
      rc_r   <= aesd_pkg::RCON_FIRST;
    end else if (busy_r) begin
      cur_r <= aesd_pkg::next_round_key(cur_r, rc_r);
      rc_r  <= aesd_pkg::xtime(rc_r);
      idx_r <= idx_r + 1'b1;
      if (idx_r == aesd_pkg::RK_IDX_W'(aesd_pkg::ROUNDS)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && !start) begin
      mem[idx_r] <= cur_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

endmodule

FILE: hdl/aesd_core.sv
`timescale 1ns / 1ps

module aesd_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          hold,
  input  aesd_pkg::chain_cfg_t          chain_cfg,
  input  logic [127:0]                  rk,
  output logic [aesd_pkg::RK_IDX_W-1:0] rk_addr,
  aesd_in_if.sink                       in_itf,
  aesd_out_if.source                    out_itf
);

  aesd_pkg::core_state_t state_r, state_nxt;

  logic [aesd_pkg::RK_IDX_W-1:0] cnt_r;
  logic [127:0]                  st_r;
  logic [127:0]                  chain_r;
  logic [127:0]                  prev_r;
  logic                          out_valid_r;
  logic [127:0]                  out_data_r;

  logic accept;
  logic finish;
  logic in_ready;

  assign accept = in_itf.valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      aesd_pkg::ST_IDLE: if (accept) state_nxt = aesd_pkg::ST_RUN;
      aesd_pkg::ST_RUN:  if (finish) state_nxt = aesd_pkg::ST_IDLE;
      default:           state_nxt = aesd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    finish   = 1'b0;
    rk_addr  = aesd_pkg::RK_IDX_W'(aesd_pkg::ROUNDS);
    unique case (state_r)
      aesd_pkg::ST_IDLE: begin
        in_ready = !hold;
      end
      aesd_pkg::ST_RUN: begin
        finish  = (cnt_r == '0) && (!out_valid_r || out_itf.ready);
        rk_addr = (cnt_r == '0) ? '0 : cnt_r - 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aesd_pkg::ST_IDLE;
      cnt_r       <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= finish || (out_valid_r && !out_itf.ready);
      if (accept) begin
        cnt_r  <= aesd_pkg::RK_IDX_W'(aesd_pkg::ROUNDS);
        prev_r <= {in_itf.ct_high, in_itf.ct_low};
      end else if (state_r == aesd_pkg::ST_RUN && cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_r <= {in_itf.ct_high, in_itf.ct_low};
      if (!chain_cfg.chain_mode) begin
        chain_r <= '0;
      end else if (in_itf.first_block) begin
        chain_r <= chain_cfg.iv;
      end else begin
        chain_r <= prev_r;
      end
    end else if (state_r == aesd_pkg::ST_RUN) begin
      if (cnt_r == aesd_pkg::RK_IDX_W'(aesd_pkg::ROUNDS)) begin
        st_r <= st_r ^ rk;
      end else if (cnt_r != '0) begin
        st_r <= aesd_pkg::inv_mix(aesd_pkg::inv_shift_sub(st_r) ^ rk);
      end
    end
    if (finish) begin
      out_data_r <= aesd_pkg::inv_shift_sub(st_r) ^ rk ^ chain_r;
    end
  end

  assign in_itf.ready    = in_ready;
  assign out_itf.valid   = out_valid_r;
  assign out_itf.pt_high = out_data_r[127:64];
  assign out_itf.pt_low  = out_data_r[63:0];

endmodule

FILE: hdl/aes128_block_decrypt.sv
`timescale 1ns / 1ps
// AES-128 block decryption with optional CBC chaining.
// The in_itf channel takes one ciphertext block per item as ct_high and
// ct_low, plus first_block, which selects the IV instead of the previous
// ciphertext block as the chaining value. The out_itf channel returns the
// plaintext block as pt_high and pt_low, one result item per input item.
// The cfg_itf channel writes the key halves, the IV halves and chain_mode
// by register index; it is always ready. The user must write it only while
// idle; the block does not enforce this. A key write starts a new round key
// expansion into the key memory, during which no item is accepted.
// An item is accepted only while no other block is in work. The rounds run
// on a single round unit fed from the registered key memory, and the next
// item can be taken as soon as the result is valid.
// If the receiver stalls, the result is held in the output register; the
// next block may run meanwhile but finishes only once that register frees.
// Reset clears the key, IV, mode and previous block to zero and expands the
// all-zero key before the first item is accepted.
module aes128_block_decrypt (
  input  logic       clk,
  input  logic       rst_n,
  aesd_in_if.sink    in_itf,
  aesd_out_if.source out_itf,
  aesd_cfg_if.sink   cfg_itf
);

  logic [127:0] key_r;
  logic [127:0] iv_r;
  logic         chain_mode_r;
  logic         exp_start_r;

  logic                          cfg_wr;
  logic [127:0]                  rk;
  logic [aesd_pkg::RK_IDX_W-1:0] rk_addr;
  logic                          exp_busy;
  aesd_pkg::chain_cfg_t          chain_cfg;

  assign cfg_itf.ready = 1'b1;
  assign cfg_wr        = cfg_itf.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r        <= '0;
      iv_r         <= '0;
      chain_mode_r <= 1'b0;
      exp_start_r  <= 1'b0;
    end else begin
      exp_start_r <= 1'b0;
      if (cfg_wr) begin
        unique case (cfg_itf.index)
          aesd_pkg::REG_KEY_HIGH: begin
            key_r[127:64] <= cfg_itf.data;
            exp_start_r   <= 1'b1;
          end
          aesd_pkg::REG_KEY_LOW: begin
            key_r[63:0] <= cfg_itf.data;
            exp_start_r <= 1'b1;
          end
          aesd_pkg::REG_IV_HIGH:    iv_r[127:64] <= cfg_itf.data;
          aesd_pkg::REG_IV_LOW:     iv_r[63:0]   <= cfg_itf.data;
          aesd_pkg::REG_CHAIN_MODE: chain_mode_r <= cfg_itf.data[0];
          default: begin
            exp_start_r <= 1'b0;
          end
        endcase
      end
    end
  end

  assign chain_cfg.iv         = iv_r;
  assign chain_cfg.chain_mode = chain_mode_r;

  aesd_keymem u_keymem (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (exp_start_r),
    .key     (key_r),
    .rd_addr (rk_addr),
    .rd_data (rk),
    .busy    (exp_busy)
  );

  aesd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .hold      (exp_busy || exp_start_r),
    .chain_cfg (chain_cfg),
    .rk        (rk),
    .rk_addr   (rk_addr),
    .in_itf    (in_itf),
    .out_itf   (out_itf)
  );

endmodule
